// ----- design/arate_pkg.sv -----
// Package for the angle rate estimator: word types, field widths, defaults.
// No dependencies; used by every module of the block.

package arate_pkg;

  localparam int unsigned ANGLE_W = 16;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned RATE_W  = 16;
  localparam int unsigned DIFF_W  = ANGLE_W + 1;

  // |diff| * 1000 < 2^26, so the divider works on 26-bit magnitudes
  localparam int unsigned DIV_W   = 26;
  localparam int unsigned NUM_W   = DIV_W + 1;
  localparam int unsigned CNT_W   = $clog2(DIV_W);

  localparam int unsigned VELOCITY_TAPS_DEF = 4;
  localparam int unsigned ACCEL_TAPS_DEF    = 4;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle_sample;
    logic        [TIME_W-1:0]  time_us;
  } in_word_t;

  typedef struct packed {
    logic signed [RATE_W-1:0] velocity;
    logic signed [RATE_W-1:0] acceleration;
    logic                     rates_valid;
  } out_word_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- design/arate_div.sv -----
// Bit-serial signed divider, one quotient bit per cycle, truncating toward zero.
// Returns the low 16 quotient bits. Depends on arate_pkg.

module arate_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [arate_pkg::NUM_W-1:0]   num_i,
  input  logic signed [arate_pkg::TIME_W-1:0]  den_i,
  output logic signed [arate_pkg::RATE_W-1:0]  quot_o,
  output arate_pkg::div_stat_t                 stat_o
);

  localparam int unsigned DW = arate_pkg::DIV_W;
  localparam int unsigned TW = arate_pkg::TIME_W;
  localparam int unsigned RW = arate_pkg::RATE_W;
  localparam int unsigned CW = arate_pkg::CNT_W;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [DW-1:0]         rem_q, rem_d;
  logic [DW-1:0]         quo_q, quo_d;
  logic [TW-1:0]         dmag_q, dmag_d;
  logic                  neg_q, neg_d;
  logic signed [RW-1:0]  res_q, res_d;

  logic [arate_pkg::NUM_W-1:0] nabs;
  logic [DW:0]                 sh;
  logic [TW-1:0]               sub;
  logic                        ge;
  logic [RW-1:0]               qlo;

  always_comb begin
    nabs = num_i[arate_pkg::NUM_W-1] ? (~num_i + 1'b1) : num_i;
    sh   = {rem_q, quo_q[DW-1]};
    ge   = TW'(sh) >= dmag_q;
    sub  = TW'(sh) - dmag_q;
    qlo  = {quo_q[RW-2:0], ge};

    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dmag_d = dmag_q;
    neg_d  = neg_q;
    res_d  = res_q;

    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = nabs[DW-1:0];
      dmag_d = den_i[TW-1] ? (~den_i + 1'b1) : den_i;
      neg_d  = num_i[arate_pkg::NUM_W-1] ^ den_i[TW-1];
    end else if (busy_q) begin
      rem_d = ge ? sub[DW-1:0] : sh[DW-1:0];
      quo_d = {quo_q[DW-2:0], ge};
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(DW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        res_d  = neg_q ? -qlo : qlo;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    dmag_q <= dmag_d;
    neg_q  <= neg_d;
    res_q  <= res_d;
  end

  assign quot_o      = res_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

// ----- design/arate_avg.sv -----
// Moving-average ring: holds the last TAPS rates, their running sum and fill count.
// Depends on arate_pkg.

module arate_avg #(
  parameter int unsigned TAPS = arate_pkg::VELOCITY_TAPS_DEF,
  localparam int unsigned SLOT_W = (TAPS > 1) ? $clog2(TAPS) : 1,
  localparam int unsigned FILL_W = $clog2(TAPS + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push_i,
  input  logic signed [arate_pkg::RATE_W-1:0] value_i,
  output logic signed [arate_pkg::NUM_W-1:0]  total_o,
  output logic        [FILL_W-1:0]            filled_o
);

  localparam int unsigned RW    = arate_pkg::RATE_W;
  localparam int unsigned SUM_W = RW + $clog2(TAPS);

  logic signed [RW-1:0]    ring_q [TAPS];
  logic signed [SUM_W-1:0] total_q, total_d;
  logic [SLOT_W-1:0]       slot_q, slot_d;
  logic [FILL_W-1:0]       filled_q, filled_d;

  always_comb begin
    total_d  = total_q - SUM_W'(ring_q[slot_q]) + SUM_W'(value_i);
    slot_d   = (slot_q == SLOT_W'(TAPS - 1)) ? '0 : slot_q + SLOT_W'(1);
    filled_d = (filled_q == FILL_W'(TAPS)) ? filled_q : filled_q + FILL_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(TAPS); i++) begin
        ring_q[i] <= '0;
      end
      total_q  <= '0;
      slot_q   <= '0;
      filled_q <= '0;
    end else if (push_i) begin
      ring_q[slot_q] <= value_i;
      total_q        <= total_d;
      slot_q         <= slot_d;
      filled_q       <= filled_d;
    end
  end

  assign total_o  = arate_pkg::NUM_W'(total_q);
  assign filled_o = filled_q;

endmodule

// ----- design/angle_rate_estimator.sv -----
// Top level of the angle rate estimator: sequencer, shared serial divider, two rings.
// Depends on arate_pkg, arate_div, arate_avg.
//
//   channel | signals                          | payload
//   in      | in_valid_i / in_ready_o          | in_word_i  (arate_pkg::in_word_t)
//   out     | out_valid_o / out_ready_i        | out_word_o (arate_pkg::out_word_t)
//
// A word with rates makes four passes through the one bit-serial divider from
// acceptance until ready rises again; a word without rates goes from the idle
// state straight to the last step.
// After reset all history is zero and ready is high at once.
// The next word is taken while a result waits in the output register; the
// sequencer stalls only at its last step until that register is free.

module angle_rate_estimator #(
  parameter int unsigned VELOCITY_TAPS = arate_pkg::VELOCITY_TAPS_DEF,
  parameter int unsigned ACCEL_TAPS    = arate_pkg::ACCEL_TAPS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  arate_pkg::in_word_t  in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output arate_pkg::out_word_t out_word_o
);

  localparam int unsigned AW = arate_pkg::ANGLE_W;
  localparam int unsigned TW = arate_pkg::TIME_W;
  localparam int unsigned RW = arate_pkg::RATE_W;
  localparam int unsigned DW = arate_pkg::DIFF_W;
  localparam int unsigned NW = arate_pkg::NUM_W;
  localparam int unsigned VF_W = $clog2(VELOCITY_TAPS + 1);
  localparam int unsigned AF_W = $clog2(ACCEL_TAPS + 1);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_VRATE = 6'b000010,
    ST_VAVG  = 6'b000100,
    ST_ARATE = 6'b001000,
    ST_AAVG  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   issued_q, issued_d;

  logic signed [AW-1:0] prev_angle_q;
  logic        [TW-1:0] prev_time_q;
  logic signed [RW-1:0] prev_vel_q;
  logic signed [DW-1:0] diff_q, diff_d;
  logic        [TW-1:0] elapsed_q, elapsed_d;
  logic signed [RW-1:0] vel_q, vel_d;
  logic signed [RW-1:0] acc_q, acc_d;
  logic                 rv_q, rv_d;

  logic                 out_valid_q;
  arate_pkg::out_word_t out_q;

  logic                  in_fire, out_free, rate_ok, div_state;
  logic                  div_start;
  logic signed [NW-1:0]  div_num, scaled;
  logic signed [TW-1:0]  div_den;
  logic signed [RW-1:0]  div_quot;
  arate_pkg::div_stat_t  div_stat;

  logic                  vpush, apush;
  logic signed [NW-1:0]  vel_total, acc_total;
  logic [VF_W-1:0]       vel_filled;
  logic [AF_W-1:0]       acc_filled;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign rate_ok    = (prev_time_q != '0) && (in_word_i.time_us > prev_time_q);
  assign div_state  = (state_q == ST_VRATE) || (state_q == ST_VAVG) ||
                      (state_q == ST_ARATE) || (state_q == ST_AAVG);
  assign div_start  = div_state && !issued_q;

  // x * 1000 = x * 1024 - x * 16 - x * 8
  always_comb begin
    scaled = NW'(diff_q);
    scaled = (scaled <<< 10) - (scaled <<< 4) - (scaled <<< 3);
  end

  always_comb begin
    case (state_q)
      ST_VRATE, ST_ARATE: begin
        div_num = scaled;
        div_den = elapsed_q;
      end
      ST_VAVG: begin
        div_num = vel_total;
        div_den = TW'(vel_filled);
      end
      ST_AAVG: begin
        div_num = acc_total;
        div_den = TW'(acc_filled);
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  always_comb begin
    state_d   = state_q;
    issued_d  = issued_q;
    diff_d    = diff_q;
    elapsed_d = elapsed_q;
    vel_d     = vel_q;
    acc_d     = acc_q;
    rv_d      = rv_q;
    vpush     = 1'b0;
    apush     = 1'b0;

    if (div_start) begin
      issued_d = 1'b1;
    end
    if (div_stat.done) begin
      issued_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          diff_d    = DW'(in_word_i.angle_sample) - DW'(prev_angle_q);
          elapsed_d = in_word_i.time_us - prev_time_q;
          vel_d     = '0;
          acc_d     = '0;
          rv_d      = rate_ok;
          state_d   = rate_ok ? ST_VRATE : ST_DONE;
        end
      end
      ST_VRATE: begin
        if (div_stat.done) begin
          vpush   = 1'b1;
          state_d = ST_VAVG;
        end
      end
      ST_VAVG: begin
        if (div_stat.done) begin
          vel_d   = div_quot;
          diff_d  = DW'(div_quot) - DW'(prev_vel_q);
          state_d = ST_ARATE;
        end
      end
      ST_ARATE: begin
        if (div_stat.done) begin
          apush   = 1'b1;
          state_d = ST_AAVG;
        end
      end
      ST_AAVG: begin
        if (div_stat.done) begin
          acc_d   = div_quot;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      issued_q     <= 1'b0;
      prev_angle_q <= '0;
      prev_time_q  <= '0;
      prev_vel_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
      if (in_fire) begin
        prev_angle_q <= in_word_i.angle_sample;
        prev_time_q  <= in_word_i.time_us;
      end
      if (state_q == ST_VAVG && div_stat.done) begin
        prev_vel_q <= div_quot;
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    diff_q    <= diff_d;
    elapsed_q <= elapsed_d;
    vel_q     <= vel_d;
    acc_q     <= acc_d;
    rv_q      <= rv_d;
    if (state_q == ST_DONE && out_free) begin
      out_q.velocity     <= vel_q;
      out_q.acceleration <= acc_q;
      out_q.rates_valid  <= rv_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  arate_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .quot_o  (div_quot),
    .stat_o  (div_stat)
  );

  arate_avg #(
    .TAPS (VELOCITY_TAPS)
  ) u_vel_avg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (vpush),
    .value_i  (div_quot),
    .total_o  (vel_total),
    .filled_o (vel_filled)
  );

  arate_avg #(
    .TAPS (ACCEL_TAPS)
  ) u_acc_avg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (apush),
    .value_i  (div_quot),
    .total_o  (acc_total),
    .filled_o (acc_filled)
  );

  a_idle_div_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !div_stat.busy)
    else $error("divider busy while sequencer idle");

  a_done_in_div_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.done |-> div_state)
    else $error("divider result outside a divide step");

  a_no_rate_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !rate_ok) |=> (state_q == ST_DONE && !rv_q))
    else $error("word without rates did not go straight to output");

  a_zero_when_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_word_o.rates_valid) |->
      (out_word_o.velocity == '0 && out_word_o.acceleration == '0))
    else $error("nonzero rates on a word without rates");

endmodule
